[hdl/pli_pkg.sv]
// package for the piecewise linear interpolation table core
// holds sizes, command, status and register index codes, and the sequencer state type
// no dependencies
package pli_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int MAX_ROWS_DEF   = 16;

   localparam int CMD_W    = 2;
   localparam int PTIDX_W  = 6;
   localparam int ROWIDX_W = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POINTS_W = 7;
   localparam int ROWS_W   = 5;
   localparam int CSR_IDX_W = 8;
   localparam int FRAC_W   = 16;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam cmd_type CMD_WR_TIME  = 2'd0;
   localparam cmd_type CMD_WR_VALUE = 2'd1;
   localparam cmd_type CMD_QUERY    = 2'd2;

   localparam status_type STAT_OK     = 2'd0;
   localparam status_type STAT_NO_INT = 2'd1;
   localparam status_type STAT_ROW    = 2'd2;

   localparam csr_idx_type REG_POINTS = 8'd0;
   localparam csr_idx_type REG_ROWS   = 8'd1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_T0,
      S_TL,
      S_SCAN,
      S_VAL,
      S_V0,
      S_V1,
      S_DIV,
      S_MUL,
      S_FIN,
      S_DONE
   } state_type;

endpackage

[hdl/pli_intf.sv]
// handshake channels of the interpolation table core
// depends on pli_pkg for field widths
interface pli_req_intf;
   logic                                 valid;
   logic                                 ready;
   logic [pli_pkg::CMD_W-1:0]            cmd;
   logic [pli_pkg::PTIDX_W-1:0]          point_index;
   logic [pli_pkg::ROWIDX_W-1:0]         row_index;
   logic signed [pli_pkg::DATA_W-1:0]    data_value;
   logic signed [pli_pkg::DATA_W-1:0]    query_time;
   modport source (output valid, cmd, point_index, row_index, data_value, query_time,
                   input ready);
   modport sink   (input valid, cmd, point_index, row_index, data_value, query_time,
                   output ready);
endinterface

interface pli_rsp_intf;
   logic                                 valid;
   logic                                 ready;
   logic signed [pli_pkg::DATA_W-1:0]    result_value;
   logic [pli_pkg::STATUS_W-1:0]         status;
   modport source (output valid, result_value, status, input ready);
   modport sink   (input valid, result_value, status, output ready);
endinterface

interface pli_csr_intf;
   logic                                 valid;
   logic                                 ready;
   logic [pli_pkg::CSR_IDX_W-1:0]        reg_index;
   logic [pli_pkg::DATA_W-1:0]           wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[hdl/piecewise_linear_interp_table_core.sv]
// piecewise linear interpolation table core
// depends on pli_pkg and the channel interfaces in pli_intf.sv
//
// usage
//   req_bus carries items: time write, row value write or query. Writes go
//   straight into the time or value memory and give no result. A query gives
//   one result item on rsp_bus: the row's value at query_time, clamped at the
//   ends, or zero with an error status.
//   csr_bus writes points_in_use (index 0) and rows_in_use (index 1); it is
//   always ready and other indexes are dropped.
// query sequence
//   a query is read from two memories with registered read data by a
//   sequencer: it checks for a clamp at the first point, then at the last
//   point, then scans for an exact match at point k or for interval k to
//   interpolate in; the scan reads one breakpoint per cycle and the Q0.16
//   fraction comes from a 16-step restoring divider. One query is in flight
//   at a time.
// reset and stall
//   reset clears the sequencer, the output valid flag and the registers
//   (points 2, rows 1); the memories are not cleared. The result waits in an
//   output register while rsp_bus stalls and the next item is accepted.
module piecewise_linear_interp_table_core #(
   parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
   parameter int MAX_ROWS   = pli_pkg::MAX_ROWS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pli_req_intf.sink    req_bus,
   pli_rsp_intf.source  rsp_bus,
   pli_csr_intf.sink    csr_bus
);
   import pli_pkg::*;

   localparam int PT_W  = $clog2(MAX_POINTS);
   localparam int VA_W  = $clog2(MAX_ROWS * MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int VDEPTH = MAX_ROWS * MAX_POINTS;
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;

   state_type state_ff, state_in;

   // configuration registers
   logic [POINTS_W-1:0] points_ff;
   logic [ROWS_W-1:0]   rows_ff;
   logic [CNT_W-1:0]    n_cur;
   int unsigned         rows_cur;

   // memories
   logic signed [DATA_W-1:0] time_mem [MAX_POINTS];
   logic signed [DATA_W-1:0] val_mem  [VDEPTH];
   logic signed [DATA_W-1:0] time_rdata_ff, val_rdata_ff;
   logic [PT_W-1:0] time_raddr;
   logic [VA_W-1:0] val_raddr;

   // query working registers
   logic signed [DATA_W-1:0] t_ff, prev_ff, v0_ff, v1_ff;
   logic [VA_W-1:0]          base_ff, vaddr_ff;
   logic [PT_W-1:0]          idx_ff;
   logic [DATA_W-1:0]        rem_ff, den_ff;
   logic [FRAC_W-1:0]        quot_ff;
   logic [3:0]               div_cnt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] res_value_ff;
   status_type               res_status_ff;

   // output register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   status_type               rsp_status_ff;

   logic req_fire, is_query, row_bad, out_free, more_pts;
   logic t_le_rd, t_ge_rd, t0_eq, bracket;
   logic [DATA_W:0] rem_shift;
   logic            div_bit;
   logic signed [DIFF_W-1:0] vdiff;
   logic signed [PROD_W-1:0] prod_adj;

   // clamped register values
   always_comb begin
      if (points_ff < POINTS_W'(2))
         n_cur = CNT_W'(2);
      else if (32'(points_ff) > 32'(MAX_POINTS))
         n_cur = CNT_W'(MAX_POINTS);
      else
         n_cur = CNT_W'(points_ff);
      if (rows_ff == '0)
         rows_cur = 1;
      else if (32'(rows_ff) > 32'(MAX_ROWS))
         rows_cur = 32'(MAX_ROWS);
      else
         rows_cur = 32'(rows_ff);
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign is_query = (req_bus.cmd == CMD_QUERY);
   assign row_bad  = 32'(req_bus.row_index) >= rows_cur;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign more_pts = (32'(idx_ff) + 32'd2) < 32'(n_cur);

   // compares against the breakpoint just read
   assign t_le_rd = t_ff <= time_rdata_ff;
   assign t_ge_rd = t_ff >= time_rdata_ff;
   assign t0_eq   = prev_ff == t_ff;
   assign bracket = (prev_ff < t_ff) && (time_rdata_ff > t_ff);

   // divider step and product rounding
   assign rem_shift = {rem_ff, 1'b0};
   assign div_bit   = rem_shift >= {1'b0, den_ff};
   assign vdiff     = DIFF_W'(v1_ff) - DIFF_W'(v0_ff);
   assign prod_adj  = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && is_query)
               state_in = row_bad ? S_DONE : S_T0;
         end
         S_T0:   state_in = t_le_rd ? S_VAL : S_TL;
         S_TL:   state_in = t_ge_rd ? S_VAL : S_SCAN;
         S_SCAN: begin
            if (t0_eq)
               state_in = S_VAL;
            else if (bracket)
               state_in = S_V0;
            else if (!more_pts)
               state_in = S_DONE;
         end
         S_VAL:  state_in = S_DONE;
         S_V0:   state_in = S_V1;
         S_V1:   state_in = S_DIV;
         S_DIV:  state_in = (div_cnt_ff == 4'd15) ? S_MUL : S_DIV;
         S_MUL:  state_in = S_FIN;
         S_FIN:  state_in = S_DONE;
         S_DONE: state_in = out_free ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // memory read addresses
   always_comb begin
      time_raddr = '0;
      val_raddr  = vaddr_ff;
      unique case (state_ff)
         S_T0: begin
            time_raddr = PT_W'(32'(n_cur) - 32'd1);
            val_raddr  = base_ff;
         end
         S_TL: begin
            time_raddr = PT_W'(1);
            val_raddr  = VA_W'(32'(base_ff) + 32'(n_cur) - 32'd1);
         end
         S_SCAN: begin
            time_raddr = PT_W'(32'(idx_ff) + 32'd2);
            val_raddr  = VA_W'(32'(base_ff) + 32'(idx_ff));
         end
         S_V0:    val_raddr = VA_W'(32'(vaddr_ff) + 32'd1);
         default: begin
            time_raddr = '0;
            val_raddr  = vaddr_ff;
         end
      endcase
   end

   // time memory
   always_ff @(posedge clock) begin
      if (req_fire && req_bus.cmd == CMD_WR_TIME && 32'(req_bus.point_index) < 32'(MAX_POINTS))
         time_mem[PT_W'(req_bus.point_index)] <= req_bus.data_value;
      time_rdata_ff <= time_mem[time_raddr];
   end

   // value memory
   always_ff @(posedge clock) begin
      if (req_fire && req_bus.cmd == CMD_WR_VALUE
          && 32'(req_bus.point_index) < 32'(MAX_POINTS)
          && 32'(req_bus.row_index) < 32'(MAX_ROWS))
         val_mem[VA_W'(32'(req_bus.row_index) * 32'(MAX_POINTS) + 32'(req_bus.point_index))]
            <= req_bus.data_value;
      val_rdata_ff <= val_mem[val_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         points_ff    <= POINTS_W'(2);
         rows_ff      <= ROWS_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid) begin
            if (csr_bus.reg_index == REG_POINTS)
               points_ff <= csr_bus.wr_data[POINTS_W-1:0];
            else if (csr_bus.reg_index == REG_ROWS)
               rows_ff <= csr_bus.wr_data[ROWS_W-1:0];
         end
         if (state_ff == S_DONE && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // query datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            t_ff          <= req_bus.query_time;
            base_ff       <= VA_W'(32'(req_bus.row_index) * 32'(MAX_POINTS));
            res_value_ff  <= '0;
            res_status_ff <= STAT_ROW;
         end
         S_T0: begin
            prev_ff <= time_rdata_ff;
            idx_ff  <= '0;
         end
         S_SCAN: begin
            vaddr_ff <= VA_W'(32'(base_ff) + 32'(idx_ff));
            rem_ff   <= DATA_W'(t_ff - prev_ff);
            den_ff   <= DATA_W'(time_rdata_ff - prev_ff);
            if (!t0_eq && !bracket) begin
               idx_ff        <= PT_W'(32'(idx_ff) + 32'd1);
               prev_ff       <= time_rdata_ff;
               res_value_ff  <= '0;
               res_status_ff <= STAT_NO_INT;
            end
         end
         S_VAL: begin
            res_value_ff  <= val_rdata_ff;
            res_status_ff <= STAT_OK;
         end
         S_V0: v0_ff <= val_rdata_ff;
         S_V1: begin
            v1_ff      <= val_rdata_ff;
            div_cnt_ff <= '0;
         end
         S_DIV: begin
            rem_ff     <= div_bit ? DATA_W'(rem_shift - {1'b0, den_ff}) : DATA_W'(rem_shift);
            quot_ff    <= {quot_ff[FRAC_W-2:0], div_bit};
            div_cnt_ff <= div_cnt_ff + 4'd1;
         end
         S_MUL: prod_ff <= PROD_W'(vdiff * $signed({1'b0, quot_ff}));
         S_FIN: begin
            res_value_ff  <= v0_ff + DATA_W'(prod_adj >>> FRAC_W);
            res_status_ff <= STAT_OK;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_value_ff  <= res_value_ff;
               rsp_status_ff <= res_status_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.status       = rsp_status_ff;

   // checks
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_cnt_ff == 4'd15) |=> state_ff == S_MUL)
      else $error("divider did not finish after 16 steps");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded into output register");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> (32'(idx_ff) + 32'd1) < 32'(n_cur))
      else $error("scan index past last interval");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK) |-> rsp_value_ff == '0)
      else $error("error result with nonzero value");

endmodule
